// ----- rtl/core/ffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_pkg: shared types and codes for the first-fit allocator
// Result kinds, controller states, controller command and datapath status structs.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned OwnW  = 8;
  localparam logic [15:0] MemSizeReset = 16'd1024;

  typedef enum logic [2:0] {
    KIND_EVICTED   = 3'd0,
    KIND_ALLOCATED = 3'd1,
    KIND_FAILED    = 3'd2,
    KIND_UPD_DONE  = 3'd3,
    KIND_UPD_MISS  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_EMIT,
    ST_WAIT
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SCAN_ALLOC,
    OP_SCAN_VICTIM,
    OP_UPDATE,
    OP_SHIFT
  } op_e;

  typedef struct packed {
    op_e  op;
    logic start;
  } ctl_cmd_t;

  typedef struct packed {
    logic done;
    logic emit;
    logic fin;
  } dp_status_t;

endpackage

// ----- rtl/core/ffa_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_in_if / ffa_out_if: valid/ready channels of the allocator
// Request and result payloads with source and sink modports.
// ----------------------------------------------------------------------------
interface ffa_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  owner_id;
  logic [15:0] request_size;
  logic        ref_bit;
  logic        mod_bit;
  modport source (output valid, mode, owner_id, request_size, ref_bit, mod_bit,
                  input ready);
  modport sink (input valid, mode, owner_id, request_size, ref_bit, mod_bit,
                output ready);
endinterface

interface ffa_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  owner_id_res;
  logic [15:0] start_address;
  logic [15:0] segment_size;
  logic [1:0]  evicted_class;
  logic        last;
  modport source (output valid, kind, owner_id_res, start_address, segment_size,
                  evicted_class, last, input ready);
  modport sink (input valid, kind, owner_id_res, start_address, segment_size,
                evicted_class, last, output ready);
endinterface

// ----- rtl/core/first_fit_allocator_nur_eviction_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_allocator_nur_eviction_unit: first-fit allocator, NUR eviction
// Ordered segment table; allocate with eviction-and-retry, owner update.
// ----------------------------------------------------------------------------
//  channel  | dir | transfer payload
//  in_if    | in  | mode, owner_id, request_size, ref_bit, mod_bit
//  out_if   | out | kind, owner_id_res, start_address, segment_size,
//           |     | evicted_class, last
//  cfg      | in  | memory_size write (cfg_we_i, cfg_wdata_i)
//
// One item at a time. A scan visits one table entry per cycle; a split or
// removal shifts one entry per cycle. An allocate with evictions retries
// after each eviction.
// Results wait in the output register; the sequencer holds while stalled.
// Reset and a memory_size write restore one free segment at once.
// ----------------------------------------------------------------------------
module first_fit_allocator_nur_eviction_unit import ffa_pkg::*; #(
  parameter int unsigned MaxSeg = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  ffa_in_if.sink      in_if,
  ffa_out_if.source   out_if
);

  ctl_cmd_t   cmd;
  dp_status_t status;
  logic       busy, in_fire, out_fire, ovalid;

  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;
  assign in_if.ready = !busy;
  assign out_if.valid = ovalid;
  assign out_if.last  = status.fin;

  ffa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i  (in_fire),
    .out_fire_i (out_fire),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy),
    .out_valid_o(ovalid)
  );

  ffa_dp #(.MaxSeg(MaxSeg)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_wdata_i,
    .cmd_i      (cmd),
    .out_fire_i (out_fire),
    .mode_i     (in_if.mode),
    .owner_i    (in_if.owner_id),
    .req_i      (in_if.request_size),
    .r_i        (in_if.ref_bit),
    .m_i        (in_if.mod_bit),
    .status_o   (status),
    .kind_o     (out_if.kind),
    .res_owner_o(out_if.owner_id_res),
    .res_start_o(out_if.start_address),
    .res_size_o (out_if.segment_size),
    .res_cls_o  (out_if.evicted_class)
  );

  // No new item while busy
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_if.ready) else $error("accepted while busy");
  // A result only while busy
  a_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> busy) else $error("result while idle");
  // Only a final result returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_if.last) |=> busy) else $error("idle after non-final");

endmodule

// ----- rtl/core/ffa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_ctrl: allocator sequencer
// Steps the datapath through scan, shift and result phases of one item.
// ----------------------------------------------------------------------------
module ffa_ctrl import ffa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       out_fire_i,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o,
  output logic       busy_o,
  output logic       out_valid_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire_i) state_d = ST_SCAN;
      ST_SCAN: if (status_i.done) state_d = status_i.emit ? ST_EMIT : ST_SHIFT;
      ST_SHIFT: if (status_i.done) state_d = status_i.emit ? ST_EMIT : ST_SCAN;
      ST_EMIT: if (out_fire_i) state_d = status_i.fin ? ST_IDLE : ST_SHIFT;
      ST_WAIT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.start  = 1'b0;
    cmd_o.op     = OP_NONE;
    busy_o       = 1'b1;
    out_valid_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        busy_o      = 1'b0;
        cmd_o.start = in_fire_i;
      end
      ST_SCAN: cmd_o.op = OP_SCAN_ALLOC;
      ST_SHIFT: cmd_o.op = OP_SHIFT;
      ST_EMIT: out_valid_o = 1'b1;
      ST_WAIT: cmd_o.op = OP_NONE;
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// ----- rtl/core/ffa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffa_dp: segment table and scan/shift datapath
// One table entry visited per cycle; inserts and removals shift one entry
// per cycle.
// ----------------------------------------------------------------------------
module ffa_dp import ffa_pkg::*; #(
  parameter int unsigned MaxSeg = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  ctl_cmd_t    cmd_i,
  input  logic        out_fire_i,
  input  logic        mode_i,
  input  logic [7:0]  owner_i,
  input  logic [15:0] req_i,
  input  logic        r_i,
  input  logic        m_i,
  output dp_status_t  status_o,
  output logic [2:0]  kind_o,
  output logic [7:0]  res_owner_o,
  output logic [15:0] res_start_o,
  output logic [15:0] res_size_o,
  output logic [1:0]  res_cls_o
);

  localparam int unsigned IdxW = $clog2(MaxSeg + 1);
  localparam logic [IdxW-1:0] MaxCnt = IdxW'(MaxSeg);

  // Table in flip-flops; entries are read at the scan index, the victim index
  // or a shift index and its neighbors; the shift walk moves one per cycle.
  logic [15:0] st_q [MaxSeg];
  logic [15:0] ln_q [MaxSeg];
  logic        fr_q [MaxSeg];
  logic [7:0]  ow_q [MaxSeg];
  logic        rb_q [MaxSeg];
  logic        mb_q [MaxSeg];
  logic [IdxW-1:0] cnt_q;

  // phase codes within scan/shift
  typedef enum logic [2:0] {
    PH_ALLOC, PH_VICT, PH_UPD, PH_INS, PH_REL, PH_DEL
  } phase_e;

  phase_e      ph_q;
  logic [IdxW-1:0] i_q, k_q, best_q, hit_q, del_q;
  logic [2:0]  bcls_q;
  logic        found_q, fin_q, r_q, m_q, nxt_q;
  logic [7:0]  own_q;
  logic [15:0] req_q;
  logic [2:0]  kind_q;
  logic [7:0]  rown_q;
  logic [15:0] rst_q, rsz_q;
  logic [1:0]  rcls_q;
  logic        done_c, emit_c;

  assign kind_o      = kind_q;
  assign res_owner_o = rown_q;
  assign res_start_o = rst_q;
  assign res_size_o  = rsz_q;
  assign res_cls_o   = rcls_q;
  assign status_o.done = done_c;
  assign status_o.emit = emit_c;
  assign status_o.fin  = fin_q;

  logic [$clog2(MaxSeg)-1:0] ix, kx, kp;
  logic in_rng;
  assign in_rng = i_q < cnt_q;
  assign ix = i_q[$clog2(MaxSeg)-1:0];
  assign kx = k_q[$clog2(MaxSeg)-1:0];
  assign kp = kx - 1'b1;

  always_comb begin
    done_c = 1'b0;
    emit_c = 1'b0;
    if (cmd_i.op == OP_SCAN_ALLOC) begin
      // a split still has to open its slot before the grant goes out
      done_c = nxt_q;
      emit_c = nxt_q && (ph_q != PH_INS);
    end else if (cmd_i.op == OP_SHIFT) begin
      // a split ends with its grant; a release goes back to scanning
      done_c = nxt_q;
      emit_c = nxt_q && fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= IdxW'(1);
      st_q[0] <= '0;
      ln_q[0] <= MemSizeReset;
      fr_q[0] <= 1'b1;
      ph_q  <= PH_ALLOC;
      nxt_q <= 1'b0;
      fin_q <= 1'b0;
    end else begin
      nxt_q <= 1'b0;
      if (cfg_we_i) begin
        cnt_q <= IdxW'(1);
        st_q[0] <= '0;
        ln_q[0] <= cfg_wdata_i;
        fr_q[0] <= 1'b1;
      end
      if (cmd_i.start) begin
        own_q <= owner_i; req_q <= req_i;
        r_q <= r_i; m_q <= m_i;
        i_q <= '0; found_q <= 1'b0;
        fin_q <= 1'b0;
        if (mode_i) ph_q <= PH_UPD;
        else ph_q <= PH_ALLOC;
        if (!mode_i && req_i == 16'd0) begin
          ph_q <= PH_VICT; // zero request fails at once
          found_q <= 1'b1;
        end
      end
      if (out_fire_i && !fin_q) begin
        // after an eviction: free and merge, then retry allocation
        ph_q <= PH_REL;
        k_q <= best_q;
      end
      if (cmd_i.op == OP_SCAN_ALLOC && !nxt_q) begin
        unique case (ph_q)
          PH_ALLOC: begin
            if (!in_rng) begin
              ph_q <= PH_VICT; i_q <= '0; bcls_q <= 3'd4;
            end else if (fr_q[ix] && ln_q[ix] >= req_q) begin
              hit_q <= i_q;
              fr_q[ix] <= 1'b0; ow_q[ix] <= own_q;
              rb_q[ix] <= 1'b1; mb_q[ix] <= 1'b1;
              rst_q <= st_q[ix];
              kind_q <= KIND_ALLOCATED; rown_q <= own_q; rcls_q <= 2'd0;
              fin_q <= 1'b1;
              if (ln_q[ix] > req_q && cnt_q < MaxCnt) begin
                rsz_q <= req_q;
                ph_q <= PH_INS; k_q <= cnt_q;
                nxt_q <= 1'b1; fin_q <= 1'b0;
              end else begin
                rsz_q <= ln_q[ix];
                nxt_q <= 1'b1;
              end
            end else begin
              i_q <= i_q + 1'b1;
            end
          end
          PH_VICT: begin
            if (found_q) begin
              kind_q <= KIND_FAILED; rown_q <= '0; rst_q <= '0; rsz_q <= '0;
              rcls_q <= 2'd0; fin_q <= 1'b1; nxt_q <= 1'b1;
            end else if (!in_rng) begin
              if (bcls_q == 3'd4) begin
                kind_q <= KIND_FAILED; rown_q <= '0; rst_q <= '0; rsz_q <= '0;
                rcls_q <= 2'd0; fin_q <= 1'b1;
              end else begin
                kind_q <= KIND_EVICTED;
                rown_q <= ow_q[best_q[$clog2(MaxSeg)-1:0]];
                rst_q <= st_q[best_q[$clog2(MaxSeg)-1:0]];
                rsz_q <= ln_q[best_q[$clog2(MaxSeg)-1:0]];
                rcls_q <= bcls_q[1:0]; fin_q <= 1'b0;
              end
              nxt_q <= 1'b1;
            end else begin
              if (!fr_q[ix] && {1'b0, rb_q[ix], mb_q[ix]} < bcls_q) begin
                bcls_q <= {1'b0, rb_q[ix], mb_q[ix]};
                best_q <= i_q;
              end
              i_q <= i_q + 1'b1;
            end
          end
          PH_UPD: begin
            if (!in_rng) begin
              if (!found_q) begin
                kind_q <= KIND_UPD_MISS; rown_q <= '0; rst_q <= '0; rsz_q <= '0;
              end
              rcls_q <= 2'd0; fin_q <= 1'b1; nxt_q <= 1'b1;
            end else begin
              if (!fr_q[ix] && ow_q[ix] == own_q) begin
                rb_q[ix] <= r_q; mb_q[ix] <= m_q;
                if (!found_q) begin
                  found_q <= 1'b1; kind_q <= KIND_UPD_DONE; rown_q <= own_q;
                  rst_q <= st_q[ix]; rsz_q <= ln_q[ix];
                end
              end
              i_q <= i_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.op == OP_SHIFT && !nxt_q) begin
        unique case (ph_q)
          PH_INS: begin
            // move entries up until the slot after the hit is open
            if (k_q > hit_q + 1'b1) begin
              st_q[kx] <= st_q[kp]; ln_q[kx] <= ln_q[kp]; fr_q[kx] <= fr_q[kp];
              ow_q[kx] <= ow_q[kp]; rb_q[kx] <= rb_q[kp]; mb_q[kx] <= mb_q[kp];
              k_q <= k_q - 1'b1;
            end else begin
              st_q[kx] <= st_q[kp] + req_q;
              ln_q[kx] <= ln_q[kp] - req_q;
              fr_q[kx] <= 1'b1;
              ln_q[kp] <= req_q;
              cnt_q <= cnt_q + 1'b1;
              fin_q <= 1'b1; nxt_q <= 1'b1;
            end
          end
          PH_REL: begin
            fr_q[kx] <= 1'b1;
            if (k_q != '0 && fr_q[kp]) begin
              ln_q[kp] <= ln_q[kp] + ln_q[kx];
              del_q <= k_q; k_q <= k_q - 1'b1; ph_q <= PH_DEL; found_q <= 1'b0;
            end else if (k_q + 1'b1 < cnt_q && fr_q[kx + 1'b1]) begin
              ln_q[kx] <= ln_q[kx] + ln_q[kx + 1'b1];
              del_q <= k_q + 1'b1; ph_q <= PH_DEL; found_q <= 1'b1;
            end else begin
              ph_q <= PH_ALLOC; i_q <= '0; found_q <= 1'b0; nxt_q <= 1'b1;
            end
          end
          PH_DEL: begin
            if (del_q + 1'b1 < cnt_q) begin
              st_q[del_q[$clog2(MaxSeg)-1:0]] <= st_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              ln_q[del_q[$clog2(MaxSeg)-1:0]] <= ln_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              fr_q[del_q[$clog2(MaxSeg)-1:0]] <= fr_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              ow_q[del_q[$clog2(MaxSeg)-1:0]] <= ow_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              rb_q[del_q[$clog2(MaxSeg)-1:0]] <= rb_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              mb_q[del_q[$clog2(MaxSeg)-1:0]] <= mb_q[del_q[$clog2(MaxSeg)-1:0] + 1'b1];
              del_q <= del_q + 1'b1;
            end else begin
              cnt_q <= cnt_q - 1'b1;
              if (!found_q && k_q + 1'b1 < cnt_q - 1'b1
                  && fr_q[kx + 1'b1]) begin
                // predecessor merge done; now check the successor
                ln_q[kx] <= ln_q[kx] + ln_q[kx + 1'b1];
                del_q <= k_q + 1'b1; found_q <= 1'b1;
              end else begin
                ph_q <= PH_ALLOC; i_q <= '0; found_q <= 1'b0; nxt_q <= 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: first-fit allocator with NUR eviction
// A table of directed requests runs first, then full-table and memory_size
// extremes, then random requests with random content. Every result is checked
// against a segment-table predictor. Both channels idle and stall at random,
// and memory_size is rewritten between phases.
// ----------------------------------------------------------------------------
module testbench;
  import ffa_pkg::*;

  localparam int MaxSeg    = 32;
  localparam int WdogLimit = 20000;  // idle cycles

  // one result as seen on the output channel
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  owner;
    logic [15:0] start;
    logic [15:0] size;
    logic [1:0]  cls;
    logic        last;
  } alloc_res_t;

  // one request; chk marks a row whose single result is typed in
  typedef struct {
    logic        mode;
    logic [7:0]  owner;
    logic [15:0] size;
    logic        r;
    logic        m;
    logic        chk;
    alloc_res_t  res;
  } alloc_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  ffa_in_if  in_if ();
  ffa_out_if out_if ();

  first_fit_allocator_nur_eviction_unit #(.MaxSeg(MaxSeg)) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if.sink),
    .out_if     (out_if.source)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Segment table mirror
  // --------------------------------------------------------------------------
  logic [15:0] mem_units;
  logic [15:0] tbl_start [MaxSeg];
  logic [15:0] tbl_len   [MaxSeg];
  logic        tbl_free  [MaxSeg];
  logic [7:0]  tbl_owner [MaxSeg];
  logic        tbl_r     [MaxSeg];
  logic        tbl_m     [MaxSeg];
  int          tbl_cnt;

  alloc_res_t  pending_res [$];
  int          n_fail, n_res, n_evict, n_alloc, n_refused, n_items;

  function automatic void table_clear(input logic [15:0] units);
    mem_units = units;
    for (int k = 0; k < MaxSeg; k++) begin
      tbl_start[k] = '0; tbl_len[k] = '0; tbl_free[k] = 1'b0;
      tbl_owner[k] = '0; tbl_r[k] = 1'b0; tbl_m[k] = 1'b0;
    end
    tbl_len[0]  = units;
    tbl_free[0] = 1'b1;
    tbl_cnt     = 1;
  endfunction

  function automatic void move_entry(input int dst, input int src);
    tbl_start[dst] = tbl_start[src]; tbl_len[dst] = tbl_len[src];
    tbl_free[dst]  = tbl_free[src];  tbl_owner[dst] = tbl_owner[src];
    tbl_r[dst]     = tbl_r[src];     tbl_m[dst] = tbl_m[src];
  endfunction

  function automatic void drop_entry(input int i);
    for (int k = i; k + 1 < tbl_cnt; k++) move_entry(k, k + 1);
    tbl_cnt--;
  endfunction

  function automatic alloc_res_t mk_res(kind_e k, logic [7:0] o, logic [15:0] s,
                                        logic [15:0] l, logic [1:0] c, logic la);
    alloc_res_t x;
    x.kind = k; x.owner = o; x.start = s; x.size = l; x.cls = c; x.last = la;
    return x;
  endfunction

  // first fit; returns granted index or -1
  function automatic int first_fit(input logic [7:0] o, input logic [15:0] sz);
    for (int i = 0; i < tbl_cnt; i++) begin
      if (tbl_free[i] && tbl_len[i] >= sz) begin
        if (tbl_len[i] > sz && tbl_cnt < MaxSeg) begin
          for (int k = tbl_cnt; k > i + 1; k--) move_entry(k, k - 1);
          tbl_cnt++;
          tbl_start[i+1] = tbl_start[i] + sz;
          tbl_len[i+1]   = tbl_len[i] - sz;
          tbl_free[i+1]  = 1'b1;
          tbl_owner[i+1] = '0; tbl_r[i+1] = 1'b0; tbl_m[i+1] = 1'b0;
          tbl_len[i]     = sz;
        end
        tbl_free[i] = 1'b0; tbl_owner[i] = o; tbl_r[i] = 1'b1; tbl_m[i] = 1'b1;
        return i;
      end
    end
    return -1;
  endfunction

  // queue the results one request produces, updating the mirror
  function automatic void predict_alloc(input alloc_req_t q);
    int g, v, best;
    if (q.mode) begin
      g = -1;
      for (int i = 0; i < tbl_cnt; i++)
        if (!tbl_free[i] && tbl_owner[i] == q.owner) begin
          tbl_r[i] = q.r; tbl_m[i] = q.m;
          if (g < 0) g = i;
        end
      if (g < 0) pending_res.push_back(mk_res(KIND_UPD_MISS, '0, '0, '0, '0, 1'b1));
      else pending_res.push_back(mk_res(KIND_UPD_DONE, q.owner, tbl_start[g],
                                        tbl_len[g], '0, 1'b1));
      return;
    end
    if (q.size == 0) begin
      pending_res.push_back(mk_res(KIND_FAILED, '0, '0, '0, '0, 1'b1));
      return;
    end
    forever begin
      g = first_fit(q.owner, q.size);
      if (g >= 0) begin
        pending_res.push_back(mk_res(KIND_ALLOCATED, q.owner, tbl_start[g],
                                     tbl_len[g], '0, 1'b1));
        return;
      end
      v = -1; best = 4;
      for (int i = 0; i < tbl_cnt; i++)
        if (!tbl_free[i] && (tbl_r[i] * 2 + tbl_m[i]) < best) begin
          best = tbl_r[i] * 2 + tbl_m[i]; v = i;
        end
      if (v < 0) begin
        pending_res.push_back(mk_res(KIND_FAILED, '0, '0, '0, '0, 1'b1));
        return;
      end
      pending_res.push_back(mk_res(KIND_EVICTED, tbl_owner[v], tbl_start[v],
                                   tbl_len[v], 2'(best), 1'b0));
      // free, then merge with free neighbours
      tbl_free[v] = 1'b1;
      if (v > 0 && tbl_free[v-1]) begin
        tbl_len[v-1] = tbl_len[v-1] + tbl_len[v];
        drop_entry(v);
        v--;
      end
      if (v + 1 < tbl_cnt && tbl_free[v+1]) begin
        tbl_len[v] = tbl_len[v] + tbl_len[v+1];
        drop_entry(v + 1);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // valid stays up across a zero gap; fields change at the falling edge
  task automatic send_req(input alloc_req_t q);
    int g;
    g = gap_len();
    @(negedge clk_i);
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_if.mode <= q.mode; in_if.owner_id <= q.owner; in_if.request_size <= q.size;
    in_if.ref_bit <= q.r; in_if.mod_bit <= q.m;
    in_if.valid <= 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    // transfer accepted at this edge
    predict_alloc(q);
    if (q.chk && pending_res.size() > 0)
      pending_res[pending_res.size()-1] = q.res;
    n_items++;
  endtask

  // drop valid after the last transfer
  task automatic hold_input();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // wait for every result, then give the sequencer time to settle
  task automatic drain();
    hold_input();
    while (pending_res.size() > 0) @(posedge clk_i);
    repeat (3 * MaxSeg + 8) @(posedge clk_i);
  endtask

  task automatic write_mem_size(input logic [15:0] units);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_wdata_i <= units;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    table_clear(units);
  endtask

  function automatic alloc_req_t row(logic md, logic [7:0] o, logic [15:0] sz,
                                     logic r, logic m);
    alloc_req_t q;
    q.mode = md; q.owner = o; q.size = sz; q.r = r; q.m = m;
    q.chk = 1'b0; q.res = '0;
    return q;
  endfunction

  function automatic alloc_req_t row_chk(alloc_req_t q, alloc_res_t x);
    q.chk = 1'b1; q.res = x;
    return q;
  endfunction

  // random request; mostly allocations sized to the current memory
  function automatic alloc_req_t rand_req(input int owners);
    alloc_req_t q;
    int p = $urandom_range(0, 99);
    int top = (mem_units < 16) ? 16 : mem_units;
    q = row(1'b0, 8'($urandom_range(0, owners)), '0, 1'($urandom_range(0, 1)),
            1'($urandom_range(0, 1)));
    if (p < 35) q.mode = 1'b1;
    if (p < 5) q.owner = 8'($urandom);  // mostly misses
    if (p >= 35) begin
      if (p < 40) q.size = 16'($urandom);
      else if (p < 42) q.size = 16'hFFFF;
      else if (p < 43) q.size = '0;
      else q.size = 16'($urandom_range(1, top / 4 + 1));
    end
    if (p >= 95) q.owner = 8'($urandom);  // full owner range, bits both ways
    return q;
  endfunction

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    alloc_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = mk_res(kind_e'(out_if.kind), out_if.owner_id_res, out_if.start_address,
                   out_if.segment_size, out_if.evicted_class, out_if.last);
      n_res++;
      if (pending_res.size() == 0) begin
        $error("unexpected result kind=%0d owner=%0d", got.kind, got.owner);
        n_fail++;
      end else begin
        want = pending_res.pop_front();
        if (got.kind == KIND_EVICTED) n_evict++;
        if (got.kind == KIND_ALLOCATED) n_alloc++;
        if (got.kind == KIND_FAILED) n_refused++;
        if (got.kind != want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, got.kind); n_fail++;
        end
        if (got.owner != want.owner) begin
          $error("owner_id_res: expected %0d, got %0d", want.owner, got.owner);
          n_fail++;
        end
        if (got.start != want.start) begin
          $error("start_address: expected %0d, got %0d", want.start, got.start);
          n_fail++;
        end
        if (got.size != want.size) begin
          $error("segment_size: expected %0d, got %0d", want.size, got.size);
          n_fail++;
        end
        if (got.cls != want.cls) begin
          $error("evicted_class: expected %0d, got %0d", want.cls, got.cls);
          n_fail++;
        end
        if (got.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, got.last); n_fail++;
        end
      end
    end
  end

  // receiver stalls: stretches of full rate, short and occasional long stalls
  int stall_left = 0;
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdogLimit) begin
      $display("watchdog: no transfer in %0d cycles", WdogLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  alloc_req_t dir_tbl [$];

  initial begin
    in_if.valid <= 1'b0; in_if.mode <= 1'b0; in_if.owner_id <= '0;
    in_if.request_size <= '0; in_if.ref_bit <= 1'b0; in_if.mod_bit <= 1'b0;
    n_fail = 0; n_res = 0; n_evict = 0; n_alloc = 0; n_refused = 0; n_items = 0;
    table_clear(MemSizeReset);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part on the reset memory size
    dir_tbl.push_back(row_chk(row(1'b1, 8'd5, '0, 1'b1, 1'b1),
                              mk_res(KIND_UPD_MISS, '0, '0, '0, '0, 1'b1)));
    dir_tbl.push_back(row_chk(row(1'b0, 8'd1, 16'd0, 1'b0, 1'b0),
                              mk_res(KIND_FAILED, '0, '0, '0, '0, 1'b1)));
    dir_tbl.push_back(row_chk(row(1'b0, 8'd1, 16'd100, 1'b0, 1'b0),
                              mk_res(KIND_ALLOCATED, 8'd1, '0, 16'd100, '0, 1'b1)));
    dir_tbl.push_back(row(1'b0, 8'd0, 16'd1, 1'b0, 1'b0));      // owner zero
    dir_tbl.push_back(row(1'b0, 8'd255, 16'd200, 1'b1, 1'b1));
    dir_tbl.push_back(row(1'b0, 8'd1, 16'd50, 1'b0, 1'b0));     // duplicate owner
    dir_tbl.push_back(row(1'b1, 8'd1, '0, 1'b0, 1'b1));         // update every segment of owner 1
    dir_tbl.push_back(row(1'b1, 8'd255, 16'hFFFF, 1'b0, 1'b0));
    dir_tbl.push_back(row(1'b1, 8'd0, '0, 1'b1, 1'b0));
    dir_tbl.push_back(row(1'b0, 8'd7, 16'd700, 1'b0, 1'b0));    // evicts by class
    dir_tbl.push_back(row(1'b0, 8'd9, 16'd1024, 1'b0, 1'b0));   // evicts everything
    dir_tbl.push_back(row(1'b0, 8'd3, 16'hFFFF, 1'b0, 1'b0));   // nothing fits at all
    for (int k = 0; k < dir_tbl.size(); k++) send_req(dir_tbl[k]);
    drain();

    // full table: 31 single units then a grant of the whole remainder
    write_mem_size(16'd40);
    for (int k = 0; k < MaxSeg - 1; k++)
      send_req(row(1'b0, 8'(k + 10), 16'd1, 1'b0, 1'b0));
    send_req(row(1'b0, 8'd170, 16'd2, 1'b0, 1'b0));
    send_req(row(1'b1, 8'd12, '0, 1'b0, 1'b0));
    send_req(row(1'b0, 8'd171, 16'd1, 1'b0, 1'b0));
    drain();

    // extremes of memory_size
    write_mem_size(16'd0);
    send_req(row_chk(row(1'b0, 8'd1, 16'd1, 1'b0, 1'b0),
                     mk_res(KIND_FAILED, '0, '0, '0, '0, 1'b1)));
    drain();
    write_mem_size(16'hFFFF);
    send_req(row_chk(row(1'b0, 8'd2, 16'hFFFF, 1'b0, 1'b0),
                     mk_res(KIND_ALLOCATED, 8'd2, '0, 16'hFFFF, '0, 1'b1)));
    send_req(row(1'b0, 8'd4, 16'd1, 1'b0, 1'b0));
    drain();

    // random phases over several memory sizes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_mem_size(16'd64);
        1: write_mem_size(16'd1);
        2: write_mem_size(16'($urandom_range(100, 5000)));
        3: write_mem_size(16'hFFFF);
        default: write_mem_size(16'd1024);
      endcase
      for (int k = 0; k < 45; k++) begin
        send_req(rand_req((ph == 1) ? 3 : 24));
        if (k == 22) begin
          hold_input();
          while (pending_res.size() > 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("Covered %0d requests, %0d results: %0d evictions, %0d grants, %0d refusals",
             n_items, n_res, n_evict, n_alloc, n_refused);
    $display("memory sizes 0, 1, 40, 64, 1024, 65535 and a random size");
    if (n_fail == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
